// ----- design/wssd_pkg.sv -----
// Shared types and constants of the window spread stability detector.
// No dependencies.
package wssd_pkg;

   localparam int WindowDepthDefault = 512;
   localparam int ChannelsDefault    = 32;

   typedef enum logic [2:0] {
      PH_IDLE    = 3'd0,
      PH_SETTLE1 = 3'd1,
      PH_DWELL1  = 3'd2,
      PH_SETTLE2 = 3'd3,
      PH_DWELL2  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_WAIT,
      ST_SUM,
      ST_DIV,
      ST_STORE,
      ST_SCAN,
      ST_DECIDE
   } step_type;

   localparam logic [2:0] CSR_SETPOINT  = 3'd0;
   localparam logic [2:0] CSR_TOLERANCE = 3'd1;
   localparam logic [2:0] CSR_SPREAD    = 3'd2;
   localparam logic [2:0] CSR_WINLEN    = 3'd3;
   localparam logic [2:0] CSR_DWELL     = 3'd4;
   localparam logic [2:0] CSR_MASK      = 3'd5;

   localparam logic [1:0] EV_CORRECT = 2'd0;
   localparam logic [1:0] EV_STABLE  = 2'd1;
   localparam logic [1:0] EV_ABORT   = 2'd2;

   // control word from the sequencer to the cell chain
   typedef struct packed {
      logic load;   // load chain from the latest readings
      logic shift;  // advance the chain by one cell
   } chain_ctl_type;

endpackage

// ----- design/wssd_cell.sv -----
// One cell of the reading chain: holds one channel's newest reading.
// Depends on wssd_pkg.
module wssd_cell
   import wssd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               wr_en,
   input  logic signed [15:0] wr_val,
   input  logic               sel,
   input  chain_ctl_type      ctl,
   input  logic signed [15:0] prev_val,
   input  logic               prev_sel,
   output logic signed [15:0] out_val,
   output logic               out_sel
);
   logic signed [15:0] chan_ff;
   logic signed [15:0] pass_ff, pass_in;
   logic               psel_ff, psel_in;

   always_ff @(posedge clock) begin
      if (reset) chan_ff <= '0;
      else if (wr_en) chan_ff <= wr_val;
      pass_ff <= pass_in;
      psel_ff <= psel_in;
   end

   // load the stored reading, then hand it down the chain one cell a cycle
   always_comb begin
      pass_in = pass_ff;
      psel_in = psel_ff;
      if (ctl.load) begin
         // the reading that ends the scan lands here on the same edge
         pass_in = wr_en ? wr_val : chan_ff;
         psel_in = sel;
      end else if (ctl.shift) begin
         pass_in = prev_val;
         psel_in = prev_sel;
      end
   end

   assign out_val = pass_ff;
   assign out_sel = psel_ff;
endmodule

// ----- design/window_spread_stability_detector_core.sv -----
// Top level of the window spread stability detector.
// Depends on wssd_pkg and wssd_cell.
//
// Readings are kept in a chain of cells, one per channel. A scan end is
// folded in sequence: the chain is summed, then the average is formed one
// quotient bit per cycle (a shift-subtract divider, 21 steps), then on a
// settling scan the window is read one entry per cycle through the single
// memory port. Ordinary readings are only written into their cell. The
// window memory needs no clearing pass; entries are read only after this
// round wrote them.
module window_spread_stability_detector_core
   import wssd_pkg::*;
#(
   parameter int WINDOW_DEPTH = WindowDepthDefault,
   parameter int CHANNELS     = ChannelsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [4:0]         req_channel,
   input  logic signed [15:0] req_reading,
   input  logic               req_scan_ok,
   input  logic               req_scan_end,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_res,
   output logic signed [15:0] rsp_new_setpoint,
   output logic signed [15:0] rsp_scan_average,
   output logic [15:0]        rsp_window_spread,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   localparam int AW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int LW = $clog2(WINDOW_DEPTH + 1);
   localparam int CW = $clog2(CHANNELS + 1);

   // configuration
   logic signed [15:0] setpoint_ff;
   logic [14:0] tolerance_ff, spread_limit_ff;
   logic [9:0]  window_len_ff;
   logic [15:0] dwell_count_ff;
   logic [31:0] channel_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         setpoint_ff     <= '0;
         tolerance_ff    <= 15'd50;
         spread_limit_ff <= 15'd20;
         window_len_ff   <= 10'd300;
         dwell_count_ff  <= '0;
         channel_mask_ff <= 32'd1;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SETPOINT:  setpoint_ff     <= csr_data[15:0];
            CSR_TOLERANCE: tolerance_ff    <= csr_data[14:0];
            CSR_SPREAD:    spread_limit_ff <= csr_data[14:0];
            CSR_WINLEN:    window_len_ff   <= csr_data[9:0];
            CSR_DWELL:     dwell_count_ff  <= csr_data[15:0];
            CSR_MASK:      channel_mask_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // effective window length
   logic [LW-1:0] eff_len;
   always_comb begin
      if (window_len_ff == '0) eff_len = LW'(1);
      else if (32'(window_len_ff) > 32'(WINDOW_DEPTH)) eff_len = LW'(WINDOW_DEPTH);
      else eff_len = LW'(window_len_ff);
   end

   // sequencer state
   step_type  step_ff, step_in;
   phase_type phase_ff;
   logic [AW-1:0] wp_ff;
   logic [LW-1:0] fill_ff;
   logic [15:0]   dwell_ff;
   logic signed [15:0] avg_ff;
   logic [15:0]   spread_ff;
   logic [CW-1:0] cnt_ff;      // chain step / selected count
   logic [LW-1:0] k_ff;        // window scan index
   logic signed [20:0] sum_ff;
   logic [4:0]    bit_ff;      // divider step
   logic [20:0]   rem_ff, quo_ff, mag_ff;
   logic          neg_ff;
   logic signed [15:0] lo_ff, hi_ff;
   logic          rd_ok_ff;

   logic          out_valid_ff;
   logic [1:0]    out_ev_ff;
   logic signed [15:0] out_nsp_ff, out_avg_ff;
   logic [15:0]   out_spr_ff;

   assign req_ready = (step_ff == ST_WAIT) && !out_valid_ff;
   logic acc;
   assign acc = req_valid && req_ready;

   // cell chain
   chain_ctl_type ctl;
   logic signed [15:0] cval [CHANNELS+1];
   logic               csel [CHANNELS+1];
   assign cval[0] = '0;
   assign csel[0] = 1'b0;
   assign ctl.load  = acc && req_kind && req_scan_end && req_scan_ok
                      && phase_ff != PH_IDLE;
   assign ctl.shift = (step_ff == ST_SUM);

   for (genvar g = 0; g < CHANNELS; g++) begin : g_cell
      wssd_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (acc && req_kind && 32'(req_channel) == g),
         .wr_val  (req_reading),
         .sel     (channel_mask_ff[g]),
         .ctl     (ctl),
         .prev_val(cval[g]),
         .prev_sel(csel[g]),
         .out_val (cval[g+1]),
         .out_sel (csel[g+1])
      );
   end

   // window memory
   logic signed [15:0] win_mem [WINDOW_DEPTH];
   logic signed [15:0] rd_ff;
   logic [AW-1:0] rd_addr;
   logic          wr_mem;
   always_ff @(posedge clock) begin
      if (wr_mem) win_mem[wp_ff] <= avg_ff;
      rd_ff <= win_mem[rd_addr];
   end
   logic [AW:0] base;
   always_comb begin
      base = (AW+1)'(wp_ff) + (AW+1)'(WINDOW_DEPTH) - (AW+1)'(eff_len)
             + (AW+1)'(k_ff);
      if (base >= (AW+1)'(WINDOW_DEPTH)) base = base - (AW+1)'(WINDOW_DEPTH);
      if (base >= (AW+1)'(WINDOW_DEPTH)) base = base - (AW+1)'(WINDOW_DEPTH);
      rd_addr = base[AW-1:0];
   end
   assign wr_mem = (step_ff == ST_STORE);

   // next step
   logic settle;
   assign settle = (phase_ff == PH_SETTLE1) || (phase_ff == PH_SETTLE2);
   always_comb begin
      step_in = step_ff;
      unique case (step_ff)
         ST_WAIT:   if (ctl.load) step_in = ST_SUM;
         ST_SUM:    if (cnt_ff == CW'(CHANNELS)) step_in = ST_DIV;
         ST_DIV:    if (bit_ff == 5'd0 && rd_ok_ff)
                       step_in = settle ? ST_STORE : ST_DECIDE;
         ST_STORE:  step_in = ST_SCAN;
         ST_SCAN:   if (k_ff == eff_len || !rd_ok_ff) step_in = ST_DECIDE;
         ST_DECIDE: step_in = ST_WAIT;
         default:   step_in = ST_WAIT;
      endcase
   end

   // remainder trial for the divider
   logic [21:0] trial;
   assign trial = {rem_ff, mag_ff[20]} - 22'(cnt_ff);

   logic signed [16:0] gap;
   logic [16:0]        gap_mag;
   logic signed [17:0] nsp;
   assign gap     = 17'(avg_ff) - 17'(setpoint_ff);
   assign gap_mag = gap[16] ? 17'(-gap) : 17'(gap);
   assign nsp     = 18'(setpoint_ff) * 18'sd2 - 18'(avg_ff);
   logic signed [15:0] nsp_sat;
   always_comb begin
      if (nsp > 18'sd32767) nsp_sat = 16'sd32767;
      else if (nsp < -18'sd32768) nsp_sat = -16'sd32768;
      else nsp_sat = nsp[15:0];
   end
   logic [15:0] spr_now;
   assign spr_now = 16'(hi_ff - lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_WAIT; phase_ff <= PH_IDLE;
         wp_ff <= '0; fill_ff <= '0; dwell_ff <= '0;
         avg_ff <= '0; spread_ff <= '0; out_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (out_valid_ff && rsp_ready) out_valid_ff <= 1'b0;
         case (step_ff)
            ST_WAIT: if (acc) begin
               if (!req_kind) begin
                  phase_ff <= PH_SETTLE1; wp_ff <= '0; fill_ff <= '0;
                  dwell_ff <= '0; avg_ff <= '0; spread_ff <= '0;
               end else if (req_scan_end && phase_ff != PH_IDLE && !req_scan_ok) begin
                  phase_ff <= PH_IDLE;
                  out_valid_ff <= 1'b1; out_ev_ff <= EV_ABORT; out_nsp_ff <= '0;
                  out_avg_ff <= avg_ff; out_spr_ff <= spread_ff;
               end
               cnt_ff <= '0; sum_ff <= '0;
            end
            ST_SUM: begin
               // accumulate what falls out of the chain end
               if (csel[CHANNELS]) sum_ff <= sum_ff + 21'(cval[CHANNELS]);
               cnt_ff <= cnt_ff + CW'(1);
               if (cnt_ff == CW'(CHANNELS)) begin
                  bit_ff <= 5'd21; rem_ff <= '0; quo_ff <= '0; rd_ok_ff <= 1'b0;
                  neg_ff <= sum_ff[20] ^ (csel[CHANNELS] & cval[CHANNELS][15]);
               end
            end
            ST_DIV: begin
               if (!rd_ok_ff) begin
                  // first cycle: count selection, take magnitude
                  cnt_ff <= CW'($countones(channel_mask_ff[CHANNELS-1:0]));
                  mag_ff <= sum_ff[20] ? 21'(-sum_ff) : 21'(sum_ff);
                  neg_ff <= sum_ff[20];
                  rd_ok_ff <= 1'b1;
               end else if (cnt_ff == '0) begin
                  avg_ff <= '0; bit_ff <= 5'd0;
               end else if (bit_ff != 5'd0) begin
                  if (!trial[21]) begin
                     rem_ff <= trial[20:0]; quo_ff <= {quo_ff[19:0], 1'b1};
                  end else begin
                     rem_ff <= {rem_ff[19:0], mag_ff[20]}; quo_ff <= {quo_ff[19:0], 1'b0};
                  end
                  mag_ff <= {mag_ff[19:0], 1'b0};
                  bit_ff <= bit_ff - 5'd1;
               end else begin
                  avg_ff <= neg_ff ? 16'(-quo_ff) : quo_ff[15:0];
               end
               k_ff <= '0;
            end
            ST_STORE: begin
               wp_ff <= (32'(wp_ff) == WINDOW_DEPTH - 1) ? '0 : wp_ff + AW'(1);
               if (32'(fill_ff) < WINDOW_DEPTH) fill_ff <= fill_ff + LW'(1);
               lo_ff <= 16'sd32767; hi_ff <= -16'sd32768;
               rd_ok_ff <= 1'b1;
            end
            ST_SCAN: begin
               if (k_ff == '0) rd_ok_ff <= (fill_ff >= eff_len);
               k_ff <= k_ff + LW'(1);
               if (k_ff != '0) begin
                  if (rd_ff < lo_ff) lo_ff <= rd_ff;
                  if (rd_ff > hi_ff) hi_ff <= rd_ff;
               end
            end
            ST_DECIDE: begin
               logic stable_now, do_end;
               stable_now = 1'b0; do_end = 1'b0;
               if (settle) begin
                  if (rd_ok_ff) begin
                     spread_ff <= spr_now;
                     if (spr_now <= 16'(spread_limit_ff)) begin
                        stable_now = 1'b1;
                        dwell_ff <= dwell_count_ff;
                        do_end = (dwell_count_ff == '0);
                        if (!do_end)
                           phase_ff <= (phase_ff == PH_SETTLE1) ? PH_DWELL1 : PH_DWELL2;
                     end
                  end
               end else begin
                  if (dwell_ff > 16'd1) dwell_ff <= dwell_ff - 16'd1;
                  else begin dwell_ff <= '0; do_end = 1'b1; end
               end
               if (do_end) begin
                  out_valid_ff <= 1'b1;
                  out_avg_ff   <= avg_ff;
                  out_spr_ff   <= (settle && rd_ok_ff) ? spr_now : spread_ff;
                  if ((phase_ff == PH_DWELL1 || (stable_now && phase_ff == PH_SETTLE1))
                      && gap_mag > 17'(tolerance_ff)) begin
                     out_ev_ff <= EV_CORRECT; out_nsp_ff <= nsp_sat;
                     phase_ff <= PH_SETTLE2; fill_ff <= '0;
                  end else begin
                     out_ev_ff <= EV_STABLE; out_nsp_ff <= '0;
                     phase_ff <= PH_IDLE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_event_res     = out_ev_ff;
   assign rsp_new_setpoint  = out_nsp_ff;
   assign rsp_scan_average  = out_avg_ff;
   assign rsp_window_spread = out_spr_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> step_ff == ST_WAIT) else $error("ready outside wait");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_res))
      else $error("result dropped");
   a_idle_after: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) && rsp_event_res != EV_CORRECT |-> phase_ff == PH_IDLE)
      else $error("phase not idle after finish");
endmodule

// ----- sim/window_spread_stability_detector_core_tb.sv -----
// Testbench for window_spread_stability_detector_core: drives readings, run starts and scan
// ends, predicts every event word and checks it. Depends on wssd_pkg and the core RTL.
`timescale 1ns / 1ps

module window_spread_stability_detector_core_tb;
   import wssd_pkg::*;

   localparam int Depth = 512;
   localparam int Chans = 32;
   localparam int WatchdogLimit = 200000;

   typedef struct packed {
      logic [1:0]         ev;
      logic signed [15:0] nsp;
      logic signed [15:0] avg;
      logic [15:0]        spread;
   } event_word_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_ready;
   logic req_kind = 0;
   logic [4:0] req_channel = 0;
   logic signed [15:0] req_reading = 0;
   logic req_scan_ok = 0, req_scan_end = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [1:0] rsp_event_res;
   logic signed [15:0] rsp_new_setpoint, rsp_scan_average;
   logic [15:0] rsp_window_spread;
   logic csr_write = 0;
   logic [2:0] csr_index = 0;
   logic [31:0] csr_data = 0;

   window_spread_stability_detector_core dut (.*);

   initial forever #5 clock = ~clock;

   // predictor copy of registers and state
   logic signed [15:0] m_setpoint;
   logic [14:0] m_tolerance, m_spread_limit;
   logic [9:0] m_window_len;
   logic [15:0] m_dwell_count;
   logic [31:0] m_mask;
   phase_type m_phase;
   logic signed [15:0] m_window [Depth];
   int m_wptr, m_fill, m_dwell_left;
   logic signed [15:0] m_last_avg;
   logic [15:0] m_last_spread;
   logic signed [15:0] m_chan [Chans];

   event_word_type pending_events[$];
   int errors = 0, events_seen = 0, items_sent = 0, stall_cycles = 0;
   bit idle_on = 1, rsp_hold = 0;

   function automatic event_word_type make_event(logic [1:0] ev, logic signed [15:0] nsp);
      make_event = '{ev, nsp, m_last_avg, m_last_spread};
   endfunction

   function automatic void finish_dwell();
      int gap, corr;
      if (m_phase == PH_DWELL1) begin
         gap = int'(m_last_avg) - int'(m_setpoint);
         if (gap < 0) gap = -gap;
         if (gap > int'(m_tolerance)) begin
            corr = 2 * int'(m_setpoint) - int'(m_last_avg);
            if (corr > 32767) corr = 32767;
            if (corr < -32768) corr = -32768;
            m_phase = PH_SETTLE2;
            m_fill = 0;
            pending_events.push_back(make_event(EV_CORRECT, 16'(corr)));
            return;
         end
      end
      m_phase = PH_IDLE;
      pending_events.push_back(make_event(EV_STABLE, '0));
   endfunction

   function automatic void predict_word(logic kind, logic [4:0] ch, logic signed [15:0] rd,
                                        logic ok, logic send);
      int sum, n, len, lo, hi, v;
      if (!kind) begin
         m_phase = PH_SETTLE1;
         m_wptr = 0; m_fill = 0; m_dwell_left = 0;
         m_last_avg = 0; m_last_spread = 0;
         return;
      end
      m_chan[ch] = rd;
      if (!send || m_phase == PH_IDLE) return;
      if (!ok) begin
         m_phase = PH_IDLE;
         pending_events.push_back(make_event(EV_ABORT, '0));
         return;
      end
      sum = 0; n = 0;
      for (int c = 0; c < Chans; c++)
         if (m_mask[c]) begin
            sum += m_chan[c];
            n++;
         end
      m_last_avg = (n != 0) ? 16'(sum / n) : '0;
      if (m_phase == PH_SETTLE1 || m_phase == PH_SETTLE2) begin
         m_window[m_wptr] = m_last_avg;
         m_wptr = (m_wptr + 1) % Depth;
         if (m_fill < Depth) m_fill++;
         len = (m_window_len == 0) ? 1 : (m_window_len > Depth) ? Depth : m_window_len;
         if (m_fill >= len) begin
            lo = 32767; hi = -32768;
            for (int k = 0; k < len; k++) begin
               v = m_window[(m_wptr + Depth - len + k) % Depth];
               if (v < lo) lo = v;
               if (v > hi) hi = v;
            end
            m_last_spread = 16'(hi - lo);
            if (m_last_spread <= m_spread_limit) begin
               m_phase = phase_type'(m_phase + 1);
               m_dwell_left = m_dwell_count;
               if (m_dwell_left == 0) finish_dwell();
            end
         end
         return;
      end
      if (m_dwell_left > 0) m_dwell_left--;
      if (m_dwell_left == 0) finish_dwell();
   endfunction

   // result checker and receiver stalls
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         event_word_type want;
         events_seen++;
         if (pending_events.size() == 0) begin
            $display("%0t: unexpected event word ev=%0d", $time, rsp_event_res);
            errors++;
         end else begin
            want = pending_events.pop_front();
            if (rsp_event_res !== want.ev) begin
               $display("%0t: event_res expected %0d got %0d", $time, want.ev, rsp_event_res);
               errors++;
            end
            if (rsp_new_setpoint !== want.nsp) begin
               $display("%0t: new_setpoint expected %0d got %0d", $time, want.nsp,
                        rsp_new_setpoint);
               errors++;
            end
            if (rsp_scan_average !== want.avg) begin
               $display("%0t: scan_average expected %0d got %0d", $time, want.avg,
                        rsp_scan_average);
               errors++;
            end
            if (rsp_window_spread !== want.spread) begin
               $display("%0t: window_spread expected %0d got %0d", $time, want.spread,
                        rsp_window_spread);
               errors++;
            end
         end
      end
   end

   initial begin
      int gap;
      @(negedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_ready <= 0;
            @(negedge clock);
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            rsp_ready <= 0;
            repeat (gap) @(negedge clock);
         end else begin
            rsp_ready <= 1;
            @(negedge clock);
         end
      end
   end

   // watchdog on cycles with no accepted word on either side
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WatchdogLimit) begin
         $display("FAIL window_spread_stability_detector_core");
         $finish;
      end
   end

   // valid stays high after a word until the next word, an idle gap or a quiet phase
   task automatic send_word(logic kind, logic [4:0] ch, logic signed [15:0] rd,
                            logic ok, logic send);
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 10)) @(negedge clock);
      end
      req_valid <= 1;
      req_kind <= kind; req_channel <= ch; req_reading <= rd;
      req_scan_ok <= ok; req_scan_end <= send;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_word(kind, ch, rd, ok, send);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      req_valid <= 0;
      csr_write <= 1; csr_index <= idx; csr_data <= val;
      @(negedge clock);
      csr_write <= 0;
      @(negedge clock);
      case (idx)
         CSR_SETPOINT:  m_setpoint = val[15:0];
         CSR_TOLERANCE: m_tolerance = val[14:0];
         CSR_SPREAD:    m_spread_limit = val[14:0];
         CSR_WINLEN:    m_window_len = val[9:0];
         CSR_DWELL:     m_dwell_count = val[15:0];
         CSR_MASK:      m_mask = val;
         default: ;
      endcase
   endtask

   // wait for all events, then let a slow scan finish before touching registers
   task automatic drain();
      req_valid <= 0;
      while (pending_events.size() != 0) @(negedge clock);
      repeat (700) @(negedge clock);
   endtask

   task automatic start_run();
      send_word(0, 5'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
   endtask

   // one scan: one to four readings, the last marked as scan end; a failing scan end follows when ok is low
   task automatic scan(int base, int noise, logic ok);
      int n;
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++)
         send_word(1, 5'($urandom_range(0, 3)), 16'(base + $urandom_range(0, noise)),
                   1'($urandom), i == n - 1 ? 1'b1 : 1'b0);
      if (!ok) send_word(1, 5'($urandom), 16'($urandom), 0, 1);
   endtask

   task automatic test_extremes();
      write_reg(CSR_WINLEN, 2);
      write_reg(CSR_SPREAD, 0);
      write_reg(CSR_DWELL, 0);
      write_reg(CSR_MASK, 32'h0000_000F);
      write_reg(CSR_TOLERANCE, 0);
      write_reg(CSR_SETPOINT, 32'h7FFF);
      // scans while idle only store readings
      send_word(1, 0, -16'sd32768, 1, 1);
      start_run();
      for (int c = 0; c < 4; c++) send_word(1, 5'(c), -16'sd32768, 1, c == 3);
      send_word(1, 3, -16'sd32768, 1, 1);            // correction saturates high
      for (int c = 0; c < 4; c++) send_word(1, 5'(c), 16'sd32767, 1, c == 3);
      send_word(1, 0, 16'sd32767, 1, 1);
      send_word(1, 0, 16'sd32767, 1, 1);
      drain();
      write_reg(CSR_SETPOINT, 32'hFFFF_8000);
      write_reg(CSR_MASK, 0);                          // empty mask averages to zero
      write_reg(CSR_WINLEN, 0);                        // saturates to one entry
      write_reg(CSR_DWELL, 1);
      start_run();
      send_word(1, 31, 16'sd12345, 1, 1);
      start_run();                                     // restart mid run
      send_word(1, 5, 0, 1, 1);
      send_word(1, 5, 0, 0, 1);                        // read failure aborts
      drain();
   endtask

   task automatic test_long_window();
      write_reg(CSR_WINLEN, 32'h3FF);                  // above depth: 512 entries
      write_reg(CSR_MASK, 32'hFFFF_FFFF);
      write_reg(CSR_DWELL, 0);
      write_reg(CSR_SPREAD, 32'h7FFF);
      write_reg(CSR_SETPOINT, 0);
      write_reg(CSR_TOLERANCE, 32'h7FFF);
      start_run();
      for (int s = 0; s < 512; s++) send_word(1, 5'(s), 16'($urandom), 1, 1);
      drain();
   endtask

   task automatic test_random_runs(int runs);
      int base;
      for (int r = 0; r < runs; r++) begin
         if (r == runs - 8) idle_on = 0;
         write_reg(CSR_WINLEN, $urandom_range(1, 6));
         write_reg(CSR_SPREAD, $urandom_range(0, 1) ? $urandom_range(0, 40) : $urandom);
         write_reg(CSR_DWELL, $urandom_range(0, 9) == 0 ? 16'hFFFF & 3 : $urandom_range(0, 3));
         write_reg(CSR_TOLERANCE, $urandom_range(0, 1) ? $urandom_range(0, 60) : $urandom);
         write_reg(CSR_SETPOINT, $urandom);
         write_reg(CSR_MASK, $urandom_range(0, 4) == 0 ? $urandom : $urandom_range(1, 15));
         base = $signed(16'($urandom)) / 2;
         start_run();
         for (int s = 0; s < 14; s++) begin
            if ($urandom_range(0, 40) == 0) start_run();
            scan(base, $urandom_range(0, 1) ? 20 : 300, $urandom_range(0, 30) != 0);
         end
         drain();
      end
   endtask

   // receiver holds off in its own process while words keep coming
   task automatic test_backpressure();
      write_reg(CSR_WINLEN, 1);
      write_reg(CSR_DWELL, 0);
      write_reg(CSR_SPREAD, 0);
      fork
         begin
            rsp_hold = 1;
            repeat (300) @(negedge clock);
            rsp_hold = 0;
         end
      join_none
      for (int i = 0; i < 6; i++) begin
         start_run();
         send_word(1, 0, 16'($urandom), 1, 1);
         send_word(1, 0, 16'($urandom), 1, 1);
      end
      req_valid <= 0;
      wait (!rsp_hold);
      drain();
   endtask

   initial begin
      m_setpoint = 0; m_tolerance = 50; m_spread_limit = 20; m_window_len = 300;
      m_dwell_count = 0; m_mask = 1; m_phase = PH_IDLE;
      m_wptr = 0; m_fill = 0; m_dwell_left = 0; m_last_avg = 0; m_last_spread = 0;
      foreach (m_chan[c]) m_chan[c] = 0;
      repeat (8) @(negedge clock);
      reset <= 0;
      @(negedge clock);
      test_extremes();
      test_long_window();
      test_backpressure();
      test_random_runs(12);
      repeat (100) @(negedge clock);
      $display("Sent %0d words, checked %0d events: extremes, long window, stall, random runs.",
               items_sent, events_seen);
      if (errors == 0 && pending_events.size() == 0)
         $display("PASS window_spread_stability_detector_core");
      else
         $display("FAIL window_spread_stability_detector_core");
      $finish;
   end

endmodule
